[src/xcrc_pkg.sv]
`timescale 1ns / 1ps

package xcrc_pkg;

  localparam int unsigned DEF_MAX_BLOCK_BYTES = 1024;
  localparam int unsigned DEF_ADDRESS_WIDTH   = 32;

  // result queue between the front and the back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [7:0] B_SOH  = 8'h01;
  localparam logic [7:0] B_STX  = 8'h02;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_ACK  = 8'h06;
  localparam logic [7:0] B_NAK  = 8'h15;
  localparam logic [7:0] B_CAN  = 8'h18;
  localparam logic [7:0] B_POLL = 8'h43;

  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_WRITE   = 2'd3;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STAGE  = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_CANCEL  = 3'd2;
  localparam logic [2:0] ST_LARGE   = 3'd3;
  localparam logic [2:0] ST_WFAIL   = 3'd4;

  localparam logic [1:0] REG_DEST  = 2'd0;
  localparam logic [1:0] REG_MAX   = 2'd1;
  localparam logic [1:0] REG_TRIES = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_NUM   = 3'd2,
    PH_CMP   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRCH  = 3'd5,
    PH_CRCL  = 3'd6,
    PH_WRITE = 3'd7
  } phase_t;

  // what the front decided to do with the accepted beat
  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_CANCEL,
    OP_EOT,
    OP_HEADER,
    OP_REWAIT,
    OP_NUM,
    OP_CMP,
    OP_DATA,
    OP_CRCH,
    OP_NAK_REWAIT,
    OP_ACK_REWAIT,
    OP_TOO_LARGE,
    OP_COMMIT,
    OP_WRITE_OK,
    OP_WRITE_FAIL
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [9:0]  stage_index;
    logic [7:0]  stage_data;
    logic [31:0] commit_address;
    logic [10:0] commit_length;
    logic [2:0]  status;
    logic [31:0] received_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_send(input logic [7:0] b);
    res_t r;
    r         = '0;
    r.kind    = KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [2:0] st, input logic [7:0] tx,
                                   input logic [31:0] len);
    res_t r;
    r                 = '0;
    r.kind            = KIND_DONE;
    r.tx_byte         = tx;
    r.status          = st;
    r.received_length = len;
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[src/xmodem_crc_block_receiver.sv]
`timescale 1ns / 1ps

// XMODEM-CRC / XMODEM-1K receiver. Each input beat is one event (start, received byte,
// read timeout, flash write result); the front decodes it in the cycle it is accepted,
// updates the frame state and CRC-16 (one byte per cycle while there is room) and
// pushes zero, one or two result beats into a four-entry queue. The back drains that
// queue into an output register at one result per clock while out_ready is high. An
// event is taken every cycle while the queue has two free slots, so events giving at
// most one result sustain one per cycle; events giving two results take two output
// beats. Payload bytes go out as staging beats; after a commit beat, bytes and
// timeouts are accepted but dropped until a write result event arrives.
module xmodem_crc_block_receiver import xcrc_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int unsigned ADDRESS_WIDTH   = DEF_ADDRESS_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  input  logic        write_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [9:0]  stage_index,
  output logic [7:0]  stage_data,
  output logic [31:0] commit_address,
  output logic [10:0] commit_length,
  output logic [2:0]  status,
  output logic [31:0] received_length,
  output logic        last
);

  push_t push;
  logic  room;
  logic  head_valid;
  res_t  head;
  logic  pop;

  xcrc_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
    .ADDRESS_WIDTH  (ADDRESS_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .rx_byte  (rx_byte),
    .write_ok (write_ok),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .room     (room),
    .push     (push)
  );

  xcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  xcrc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .stage_index    (stage_index),
    .stage_data     (stage_data),
    .commit_address (commit_address),
    .commit_length  (commit_length),
    .status         (status),
    .received_length(received_length),
    .last           (last)
  );

endmodule

[src/xcrc_front.sv]
`timescale 1ns / 1ps

module xcrc_front import xcrc_pkg::*; #(
  parameter int unsigned MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int unsigned ADDRESS_WIDTH   = DEF_ADDRESS_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  input  logic        write_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        room,
  output push_t       push
);

  localparam logic [10:0] LONG_LEN  = 11'(MAX_BLOCK_BYTES);
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDRESS_WIDTH) - 64'd1);

  logic [31:0] dest_address;
  logic [31:0] max_image_size;
  logic [7:0]  start_try_limit;

  phase_t      phase, phase_next;
  logic [7:0]  block_number, block_number_next;
  logic [7:0]  block_complement, block_complement_next;
  logic [10:0] payload_count, payload_count_next;
  logic        long_block, long_block_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;
  logic [7:0]  seq_block, seq_block_next;
  logic [31:0] image_offset, image_offset_next;
  logic [7:0]  poll_count, poll_count_next;

  logic        fire;
  op_t         op;
  logic [10:0] blen;
  logic [10:0] cnt_inc;
  logic [31:0] offset_adv;
  logic        blk_good, blk_dup, blk_seq, too_large;
  logic        do_rewait, rw_quiet, rw_timeout;
  logic [31:0] rw_offset;
  logic [7:0]  rw_poll;
  res_t        pre, sec;
  logic        pre_v, sec_v;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign fire      = in_valid && room;

  assign blen       = long_block ? LONG_LEN : SHORT_LEN;
  assign cnt_inc    = payload_count + 11'd1;
  assign offset_adv = image_offset + {21'd0, blen};
  assign blk_good   = (block_number == ~block_complement) &&
                      ({crc_high_byte, rx_byte} == running_crc);
  assign blk_dup    = block_number == (seq_block - 8'd1);
  assign blk_seq    = block_number == seq_block;
  assign too_large  = ({1'b0, image_offset} + {22'd0, blen}) > {1'b0, max_image_size};

  // classify the beat
  always_comb begin
    op = OP_NONE;
    if (fire) begin
      unique case (action)
        ACT_START: op = OP_START;
        ACT_BYTE: begin
          unique case (phase)
            PH_IDLE, PH_WRITE: op = OP_NONE;
            PH_WAIT: begin
              priority if (rx_byte == B_CAN)                      op = OP_CANCEL;
              else if (rx_byte == B_EOT)                          op = OP_EOT;
              else if (rx_byte == B_SOH || rx_byte == B_STX)      op = OP_HEADER;
              else                                                op = OP_REWAIT;
            end
            PH_NUM:  op = OP_NUM;
            PH_CMP:  op = OP_CMP;
            PH_DATA: op = OP_DATA;
            PH_CRCH: op = OP_CRCH;
            PH_CRCL: begin
              priority if (!blk_good) op = OP_NAK_REWAIT;
              else if (blk_dup)       op = OP_ACK_REWAIT;
              else if (!blk_seq)      op = OP_NAK_REWAIT;
              else if (too_large)     op = OP_TOO_LARGE;
              else                    op = OP_COMMIT;
            end
          endcase
        end
        ACT_TIMEOUT: begin
          unique case (phase)
            PH_IDLE, PH_WRITE: op = OP_NONE;
            PH_WAIT:           op = OP_REWAIT;
            PH_NUM, PH_CMP, PH_DATA, PH_CRCH, PH_CRCL: op = OP_NAK_REWAIT;
          endcase
        end
        ACT_WRITE: begin
          if (phase == PH_WRITE) op = write_ok ? OP_WRITE_OK : OP_WRITE_FAIL;
        end
      endcase
    end
  end

  // going back to wait for a block polls only while no data is accepted
  assign do_rewait  = (op == OP_START) || (op == OP_REWAIT) || (op == OP_NAK_REWAIT) ||
                      (op == OP_ACK_REWAIT) || (op == OP_WRITE_OK);
  assign rw_offset  = (op == OP_START) ? 32'd0 :
                      (op == OP_WRITE_OK) ? offset_adv : image_offset;
  assign rw_poll    = (op == OP_START) ? 8'd0 : poll_count;
  assign rw_quiet   = rw_offset != 32'd0;
  assign rw_timeout = rw_poll >= start_try_limit;

  // next state
  always_comb begin
    phase_next            = phase;
    block_number_next     = block_number;
    block_complement_next = block_complement;
    payload_count_next    = payload_count;
    long_block_next       = long_block;
    running_crc_next      = running_crc;
    crc_high_byte_next    = crc_high_byte;
    seq_block_next        = seq_block;
    image_offset_next     = image_offset;
    poll_count_next       = poll_count;
    unique case (op)
      OP_START: begin
        block_number_next     = 8'd0;
        block_complement_next = 8'd0;
        payload_count_next    = 11'd0;
        long_block_next       = 1'b0;
        running_crc_next      = 16'd0;
        crc_high_byte_next    = 8'd0;
        seq_block_next        = 8'd1;
        image_offset_next     = 32'd0;
        poll_count_next       = 8'd0;
      end
      OP_CANCEL, OP_EOT, OP_TOO_LARGE, OP_WRITE_FAIL: phase_next = PH_IDLE;
      OP_HEADER: begin
        long_block_next    = rx_byte == B_STX;
        payload_count_next = 11'd0;
        running_crc_next   = 16'd0;
        phase_next         = PH_NUM;
      end
      OP_NUM: begin
        block_number_next = rx_byte;
        phase_next        = PH_CMP;
      end
      OP_CMP: begin
        block_complement_next = rx_byte;
        phase_next            = PH_DATA;
      end
      OP_DATA: begin
        running_crc_next   = crc_byte(running_crc, rx_byte);
        payload_count_next = cnt_inc;
        if (cnt_inc >= blen) phase_next = PH_CRCH;
      end
      OP_CRCH: begin
        crc_high_byte_next = rx_byte;
        phase_next         = PH_CRCL;
      end
      OP_COMMIT: phase_next = PH_WRITE;
      OP_WRITE_OK: begin
        image_offset_next = offset_adv;
        seq_block_next    = seq_block + 8'd1;
      end
      OP_NONE, OP_REWAIT, OP_NAK_REWAIT, OP_ACK_REWAIT: ;
    endcase
    if (do_rewait) begin
      phase_next = PH_WAIT;
      if (!rw_quiet) begin
        if (rw_timeout) phase_next = PH_IDLE;
        else            poll_count_next = rw_poll + 8'd1;
      end
    end
  end

  // results of the beat
  always_comb begin
    pre   = '0;
    pre_v = 1'b0;
    sec   = '0;
    sec_v = 1'b0;
    unique case (op)
      OP_CANCEL: begin
        pre_v = 1'b1;
        pre   = mk_done(ST_CANCEL, 8'h00, 32'd0);
      end
      OP_EOT: begin
        pre_v = 1'b1;
        pre   = mk_done(ST_OK, B_ACK, image_offset);
      end
      OP_DATA: begin
        pre_v            = 1'b1;
        pre.kind         = KIND_STAGE;
        pre.stage_index  = payload_count[9:0];
        pre.stage_data   = rx_byte;
      end
      OP_NAK_REWAIT: begin
        pre_v = 1'b1;
        pre   = mk_send(B_NAK);
      end
      OP_ACK_REWAIT, OP_WRITE_OK: begin
        pre_v = 1'b1;
        pre   = mk_send(B_ACK);
      end
      OP_TOO_LARGE: begin
        pre_v = 1'b1;
        pre   = mk_send(B_CAN);
        sec_v = 1'b1;
        sec   = mk_done(ST_LARGE, B_CAN, 32'd0);
      end
      OP_WRITE_FAIL: begin
        pre_v = 1'b1;
        pre   = mk_send(B_CAN);
        sec_v = 1'b1;
        sec   = mk_done(ST_WFAIL, B_CAN, 32'd0);
      end
      OP_COMMIT: begin
        pre_v              = 1'b1;
        pre.kind           = KIND_COMMIT;
        pre.commit_address = (dest_address + image_offset) & ADDR_MASK;
        pre.commit_length  = blen;
      end
      OP_NONE, OP_START, OP_HEADER, OP_REWAIT, OP_NUM, OP_CMP, OP_CRCH: ;
    endcase
    if (do_rewait && !rw_quiet) begin
      sec_v = 1'b1;
      sec   = rw_timeout ? mk_done(ST_TIMEOUT, B_POLL, 32'd0) : mk_send(B_POLL);
    end

    push = '0;
    if (pre_v) begin
      push.r0 = pre;
      push.r1 = sec;
      push.n  = sec_v ? 2'd2 : 2'd1;
    end else begin
      push.r0 = sec;
      push.n  = sec_v ? 2'd1 : 2'd0;
    end
    if (push.n == 2'd2) push.r1.last = 1'b1;
    else                push.r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_address     <= 32'd0;
      max_image_size   <= 32'd0;
      start_try_limit  <= 8'd20;
      phase            <= PH_IDLE;
      block_number     <= 8'd0;
      block_complement <= 8'd0;
      payload_count    <= 11'd0;
      long_block       <= 1'b0;
      running_crc      <= 16'd0;
      crc_high_byte    <= 8'd0;
      seq_block        <= 8'd1;
      image_offset     <= 32'd0;
      poll_count       <= 8'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEST:  dest_address    <= cfg_data;
          REG_MAX:   max_image_size  <= cfg_data;
          REG_TRIES: start_try_limit <= cfg_data[7:0];
          default:   ;
        endcase
      end
      phase            <= phase_next;
      block_number     <= block_number_next;
      block_complement <= block_complement_next;
      payload_count    <= payload_count_next;
      long_block       <= long_block_next;
      running_crc      <= running_crc_next;
      crc_high_byte    <= crc_high_byte_next;
      seq_block        <= seq_block_next;
      image_offset     <= image_offset_next;
      poll_count       <= poll_count_next;
    end
  end

endmodule

[src/xcrc_queue.sv]
`timescale 1ns / 1ps

module xcrc_queue import xcrc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  head_valid,
  output res_t  head,
  input  logic  pop
);

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count, count_next;

  // a beat may push two results, so keep two slots free
  assign room       = count <= (QAW + 1)'(QDEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];
  assign count_next = count + (QAW + 1)'(push.n) - (QAW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.n);
      rd_ptr <= rd_ptr + QAW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr + QAW'(1)] <= push.r1;
  end

endmodule

[src/xcrc_back.sv]
`timescale 1ns / 1ps

module xcrc_back import xcrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  res_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [9:0]  stage_index,
  output logic [7:0]  stage_data,
  output logic [31:0] commit_address,
  output logic [10:0] commit_length,
  output logic [2:0]  status,
  output logic [31:0] received_length,
  output logic        last
);

  res_t held;

  // refill the output register when it is empty or its beat is taken
  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) held <= head;
  end

  assign kind            = held.kind;
  assign tx_byte         = held.tx_byte;
  assign stage_index     = held.stage_index;
  assign stage_data      = held.stage_data;
  assign commit_address  = held.commit_address;
  assign commit_length   = held.commit_length;
  assign status          = held.status;
  assign received_length = held.received_length;
  assign last            = held.last;

endmodule

[test/xmodem_crc_block_receiver_test.sv]
`timescale 1ns / 1ps

module xmodem_crc_block_receiver_test;
  import xcrc_pkg::*;

  localparam int unsigned LONG_LEN = DEF_MAX_BLOCK_BYTES;
  localparam int TARGET_ITEMS  = 1550;
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PRINT_CAP     = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [7:0]  rx_byte;
  logic        write_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [9:0]  stage_index;
  logic [7:0]  stage_data;
  logic [31:0] commit_address;
  logic [10:0] commit_length;
  logic [2:0]  status;
  logic [31:0] received_length;
  logic        last;

  xmodem_crc_block_receiver dut (.*);

  always #5 clk = ~clk;

  // one row of the directed part: an event or a register write
  typedef struct {
    bit          cfg;
    logic [1:0]  act;
    logic [31:0] val;
    logic        ok;
    int          nfix;
    res_t        f0;
    res_t        f1;
  } step_t;

  step_t plan[$];

  // expected result beats, oldest first
  res_t due_beats[$];
  res_t event_beats[$];
  res_t want_beat;
  res_t typed[2];
  int   typed_n;

  // receiver copy: configuration and session state
  logic [31:0] c_dest;
  logic [31:0] c_max;
  logic [7:0]  c_tries;
  phase_t      m_phase;
  logic [7:0]  m_num;
  logic [7:0]  m_cmp;
  logic [10:0] m_count;
  logic        m_long;
  logic [15:0] m_crc;
  logic [7:0]  m_crc_hi;
  logic [7:0]  m_expect;
  logic [31:0] m_offset;
  logic [7:0]  m_polls;

  int errors = 0;
  int live_items = 0;
  int dead_items = 0;
  int beats_seen = 0;
  int sessions = 0;
  int commits = 0;
  int long_blocks = 0;
  int quiet = 0;
  int ready_hold = 0;
  bit calm = 1'b0;

  function automatic res_t tx_beat(logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic res_t stage_beat(logic [9:0] idx, logic [7:0] d);
    res_t r;
    r = '0;
    r.kind = KIND_STAGE;
    r.stage_index = idx;
    r.stage_data = d;
    return r;
  endfunction

  function automatic res_t commit_beat(logic [31:0] addr, logic [10:0] len);
    res_t r;
    r = '0;
    r.kind = KIND_COMMIT;
    r.commit_address = addr;
    r.commit_length = len;
    return r;
  endfunction

  function automatic res_t done_beat(logic [2:0] st, logic [7:0] tx, logic [31:0] len);
    res_t r;
    r = '0;
    r.kind = KIND_DONE;
    r.tx_byte = tx;
    r.status = st;
    r.received_length = len;
    return r;
  endfunction

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic logic [10:0] model_block_len();
    return m_long ? 11'(LONG_LEN) : SHORT_LEN;
  endfunction

  function automatic void emit(res_t r);
    event_beats.push_back(r);
  endfunction

  function automatic void end_session(logic [2:0] st, logic [7:0] tx, logic [31:0] len);
    emit(done_beat(st, tx, len));
    m_phase = PH_IDLE;
  endfunction

  // back to waiting for a header; poll only while no data has been taken
  function automatic void model_rewait();
    m_phase = PH_WAIT;
    if (m_offset == 32'd0) begin
      if (m_polls >= c_tries) begin
        end_session(ST_TIMEOUT, B_POLL, 32'd0);
      end else begin
        m_polls++;
        emit(tx_beat(B_POLL));
      end
    end
  endfunction

  function automatic void model_end_block(logic [7:0] lo);
    logic [15:0] got;
    logic [7:0]  prev;
    logic [32:0] need;
    got = {m_crc_hi, lo};
    prev = m_expect - 8'd1;
    need = {1'b0, m_offset} + {22'd0, model_block_len()};
    if (m_num != ~m_cmp || got != m_crc) begin
      emit(tx_beat(B_NAK));
      model_rewait();
    end else if (m_num == prev) begin
      emit(tx_beat(B_ACK));
      model_rewait();
    end else if (m_num != m_expect) begin
      emit(tx_beat(B_NAK));
      model_rewait();
    end else if (need > {1'b0, c_max}) begin
      emit(tx_beat(B_CAN));
      end_session(ST_LARGE, B_CAN, 32'd0);
    end else begin
      emit(commit_beat(c_dest + m_offset, model_block_len()));
      m_phase = PH_WRITE;
      commits++;
    end
  endfunction

  function automatic void model_byte(logic [7:0] b);
    case (m_phase)
      PH_WAIT: begin
        if (b == B_CAN) begin
          end_session(ST_CANCEL, 8'h00, 32'd0);
        end else if (b == B_EOT) begin
          end_session(ST_OK, B_ACK, m_offset);
        end else if (b == B_SOH || b == B_STX) begin
          m_long = (b == B_STX);
          m_count = '0;
          m_crc = '0;
          m_phase = PH_NUM;
        end else begin
          model_rewait();
        end
      end
      PH_NUM: begin
        m_num = b;
        m_phase = PH_CMP;
      end
      PH_CMP: begin
        m_cmp = b;
        m_phase = PH_DATA;
      end
      PH_DATA: begin
        emit(stage_beat(m_count[9:0], b));
        m_crc = crc16_update(m_crc, b);
        m_count = m_count + 11'd1;
        if (m_count >= model_block_len()) m_phase = PH_CRCH;
      end
      PH_CRCH: begin
        m_crc_hi = b;
        m_phase = PH_CRCL;
      end
      PH_CRCL: model_end_block(b);
      default: ;
    endcase
  endfunction

  function automatic void clear_session();
    m_num = '0;
    m_cmp = '0;
    m_count = '0;
    m_long = 1'b0;
    m_crc = '0;
    m_crc_hi = '0;
    m_expect = 8'd1;
    m_offset = '0;
    m_polls = '0;
  endfunction

  // returns 1 when the event leaves the receiver untouched
  function automatic bit receiver_model_step(logic [1:0] a, logic [7:0] b, logic ok);
    bit ignored;
    ignored = (a != ACT_START) &&
              (m_phase == PH_IDLE || ((m_phase == PH_WRITE) != (a == ACT_WRITE)));
    event_beats.delete();
    case (a)
      ACT_START: begin
        clear_session();
        model_rewait();
      end
      ACT_BYTE: begin
        if (m_phase != PH_IDLE && m_phase != PH_WRITE) model_byte(b);
      end
      ACT_TIMEOUT: begin
        if (m_phase == PH_WAIT) begin
          model_rewait();
        end else if (m_phase != PH_IDLE && m_phase != PH_WRITE) begin
          emit(tx_beat(B_NAK));
          model_rewait();
        end
      end
      default: begin
        if (m_phase == PH_WRITE) begin
          if (ok) begin
            m_offset = m_offset + 32'(model_block_len());
            m_expect = m_expect + 8'd1;
            emit(tx_beat(B_ACK));
            model_rewait();
          end else begin
            emit(tx_beat(B_CAN));
            end_session(ST_WFAIL, B_CAN, 32'd0);
          end
        end
      end
    endcase
    if (event_beats.size() > 0) event_beats[event_beats.size() - 1].last = 1'b1;
    return ignored;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // a byte that the receiver treats as line noise while waiting for a header
  function automatic logic [7:0] noise_byte();
    logic [7:0] d;
    do d = rand_byte(); while (d == B_SOH || d == B_STX || d == B_EOT || d == B_CAN);
    return d;
  endfunction

  function automatic step_t row_event(logic [1:0] a, logic [7:0] b, logic ok, int n,
                                      res_t f0, res_t f1);
    step_t s;
    s.cfg = 1'b0;
    s.act = a;
    s.val = {24'd0, b};
    s.ok = ok;
    s.nfix = n;
    s.f0 = f0;
    s.f1 = f1;
    return s;
  endfunction

  function automatic step_t row_cfg(logic [1:0] idx, logic [31:0] val);
    step_t s;
    s.cfg = 1'b1;
    s.act = idx;
    s.val = val;
    s.ok = 1'b0;
    s.nfix = -1;
    s.f0 = '0;
    s.f1 = '0;
    return s;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report($sformatf("beat %0d field %s: got %0h, want %0h", beats_seen, name, got, want));
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(logic [1:0] a, logic [7:0] b, logic ok);
    int gap;
    bit ignored;
    res_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    action = a;
    rx_byte = b;
    write_ok = ok;
    do @(posedge clk); while (!in_ready);
    ignored = receiver_model_step(a, b, ok);
    if (ignored) dead_items++;
    else live_items++;
    @(negedge clk);
    if (typed_n >= 0) begin
      for (int i = 0; i < typed_n; i++) begin
        beat = typed[i];
        beat.last = (i == typed_n - 1);
        due_beats.push_back(beat);
      end
    end else begin
      foreach (event_beats[i]) due_beats.push_back(event_beats[i]);
    end
  endtask

  // hold the sender until every expected beat is out and the pipe is empty
  task automatic settle();
    in_valid = 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    settle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEST:  c_dest = val;
      REG_MAX:   c_max = val;
      REG_TRIES: c_tries = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic pick_config();
    int r;
    r = $urandom_range(0, 3);
    write_reg(REG_DEST, (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FF00 : $urandom());
    r = $urandom_range(0, 9);
    case (r)
      0: write_reg(REG_MAX, 32'h0);
      1: write_reg(REG_MAX, 32'(SHORT_LEN) * $urandom_range(1, 3));
      2: write_reg(REG_MAX, $urandom());
      3: write_reg(REG_MAX, 32'd1023);
      default: write_reg(REG_MAX, 32'hFFFF_FFFF);
    endcase
    r = $urandom_range(0, 5);
    case (r)
      0: write_reg(REG_TRIES, 32'd1);
      1: write_reg(REG_TRIES, 32'd255);
      2: write_reg(REG_TRIES, 32'($urandom_range(1, 6)));
      default: write_reg(REG_TRIES, 32'd20);
    endcase
  endtask

  // header, number, complement, payload, CRC; cut_at >= 0 drops the rest for a timeout
  task automatic send_block(bit lng, logic [7:0] num, logic [7:0] cmp, bit bad_crc,
                            int cut_at);
    int len;
    logic [15:0] crc;
    logic [15:0] flip;
    logic [7:0] d;
    len = lng ? LONG_LEN : SHORT_LEN;
    crc = '0;
    flip = bad_crc ? 16'($urandom_range(1, 65535)) : 16'h0;
    send_item(ACT_BYTE, lng ? B_STX : B_SOH, rbit());
    for (int i = 0; i < len + 4; i++) begin
      if (i == cut_at) begin
        send_item(ACT_TIMEOUT, rand_byte(), rbit());
        return;
      end
      if (i == 0) begin
        d = num;
      end else if (i == 1) begin
        d = cmp;
      end else if (i < len + 2) begin
        d = rand_byte();
        crc = crc16_update(crc, d);
      end else if (i == len + 2) begin
        d = crc[15:8] ^ flip[15:8];
      end else begin
        d = crc[7:0] ^ flip[7:0];
      end
      send_item(ACT_BYTE, d, rbit());
    end
  endtask

  task automatic run_session();
    int nblk;
    int pick;
    int cut;
    int blen;
    bit lng;
    bit bad;
    logic [7:0] num;
    logic [7:0] cmp;
    settle();
    calm = ($urandom_range(0, 4) == 0);
    sessions++;
    if (sessions == 1 || $urandom_range(0, 2) == 0) pick_config();
    send_item(ACT_START, rand_byte(), rbit());
    nblk = $urandom_range(1, 5);
    for (int k = 0; k < nblk; k++) begin
      if ($urandom_range(0, 7) == 0) send_item(ACT_TIMEOUT, rand_byte(), rbit());
      if ($urandom_range(0, 9) == 0) send_item(ACT_BYTE, noise_byte(), rbit());
      if (m_phase != PH_WAIT) break;
      lng = (long_blocks == 0 && live_items > 200 && $urandom_range(0, 3) == 0);
      blen = lng ? LONG_LEN : SHORT_LEN;
      num = m_expect;
      cmp = ~m_expect;
      bad = 1'b0;
      cut = -1;
      pick = lng ? 99 : $urandom_range(0, 99);
      if (pick < 8) begin
        bad = 1'b1;
      end else if (pick < 14) begin
        cmp = cmp ^ (8'h01 << $urandom_range(0, 7));
      end else if (pick < 20) begin
        num = m_expect - 8'd1;
        cmp = ~num;
      end else if (pick < 24) begin
        num = m_expect + 8'($urandom_range(1, 200));
        cmp = ~num;
      end else if (pick < 30) begin
        cut = $urandom_range(0, blen + 3);
      end
      if (lng) long_blocks++;
      send_block(lng, num, cmp, bad, cut);
      if (m_phase == PH_WRITE) begin
        // stray traffic while the write is pending must be dropped
        if ($urandom_range(0, 5) == 0)
          send_item(rbit() ? ACT_BYTE : ACT_TIMEOUT, rand_byte(), rbit());
        send_item(ACT_WRITE, rand_byte(), $urandom_range(0, 19) != 0);
      end
      if (m_phase == PH_IDLE) break;
    end
    if (m_phase != PH_IDLE) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(ACT_BYTE, B_CAN, rbit());
      end else if (pick < 18 && m_offset == 32'd0 && c_tries <= 8'd16) begin
        while (m_phase != PH_IDLE) send_item(ACT_TIMEOUT, rand_byte(), rbit());
      end else if (pick >= 24) begin
        send_item(ACT_BYTE, B_EOT, rbit());
      end
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready = 1'b0;
      ready_hold--;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      beats_seen++;
      if (due_beats.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected (kind %0d)", beats_seen, kind));
      end else begin
        want_beat = due_beats.pop_front();
        check_field("kind", kind, want_beat.kind);
        check_field("tx_byte", tx_byte, want_beat.tx_byte);
        check_field("stage_index", stage_index, want_beat.stage_index);
        check_field("stage_data", stage_data, want_beat.stage_data);
        check_field("commit_address", commit_address, want_beat.commit_address);
        check_field("commit_length", commit_length, want_beat.commit_length);
        check_field("status", status, want_beat.status);
        check_field("received_length", received_length, want_beat.received_length);
        check_field("last", last, want_beat.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d beats still due", quiet, due_beats.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_START;
    rx_byte = 8'h00;
    write_ok = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEST;
    cfg_data = 32'h0;
    out_ready = 1'b0;
    typed_n = -1;
    c_dest = 32'h0;
    c_max = 32'h0;
    c_tries = 8'd20;
    m_phase = PH_IDLE;
    clear_session();

    // idle drops everything, then polls at reset settings, then timeouts and a cancel at small try limits
    plan.push_back(row_event(ACT_BYTE, 8'h00, 1'b0, 0, '0, '0));
    plan.push_back(row_event(ACT_TIMEOUT, 8'hFF, 1'b1, 0, '0, '0));
    plan.push_back(row_event(ACT_WRITE, 8'hA5, 1'b1, 0, '0, '0));
    plan.push_back(row_event(ACT_START, 8'h5A, 1'b0, 1, tx_beat(B_POLL), '0));
    plan.push_back(row_event(ACT_TIMEOUT, 8'h00, 1'b0, 1, tx_beat(B_POLL), '0));
    plan.push_back(row_event(ACT_BYTE, 8'hFF, 1'b1, 1, tx_beat(B_POLL), '0));
    plan.push_back(row_event(ACT_WRITE, 8'h00, 1'b0, 0, '0, '0));
    plan.push_back(row_event(ACT_BYTE, B_SOH, 1'b0, -1, '0, '0));
    plan.push_back(row_event(ACT_TIMEOUT, 8'h00, 1'b1, 2, tx_beat(B_NAK), tx_beat(B_POLL)));
    plan.push_back(row_event(ACT_BYTE, B_STX, 1'b1, -1, '0, '0));
    plan.push_back(row_event(ACT_BYTE, 8'h01, 1'b0, -1, '0, '0));
    plan.push_back(row_event(ACT_BYTE, 8'hFE, 1'b0, -1, '0, '0));
    plan.push_back(row_event(ACT_BYTE, 8'hFF, 1'b0, 1, stage_beat(10'd0, 8'hFF), '0));
    plan.push_back(row_event(ACT_BYTE, 8'h00, 1'b1, 1, stage_beat(10'd1, 8'h00), '0));
    plan.push_back(row_event(ACT_START, 8'h00, 1'b1, -1, '0, '0));
    plan.push_back(row_event(ACT_BYTE, B_EOT, 1'b0, 1, done_beat(ST_OK, B_ACK, 32'd0), '0));
    plan.push_back(row_event(ACT_BYTE, B_SOH, 1'b1, 0, '0, '0));
    plan.push_back(row_cfg(REG_TRIES, 32'd0));
    plan.push_back(row_event(ACT_START, 8'hFF, 1'b0, 1,
                             done_beat(ST_TIMEOUT, B_POLL, 32'd0), '0));
    plan.push_back(row_cfg(REG_TRIES, 32'd1));
    plan.push_back(row_event(ACT_START, 8'h00, 1'b0, -1, '0, '0));
    plan.push_back(row_event(ACT_TIMEOUT, 8'h00, 1'b0, 1,
                             done_beat(ST_TIMEOUT, B_POLL, 32'd0), '0));
    plan.push_back(row_event(ACT_START, 8'h00, 1'b1, -1, '0, '0));
    plan.push_back(row_event(ACT_BYTE, B_CAN, 1'b0, 1, done_beat(ST_CANCEL, 8'h00, 32'd0), '0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        write_reg(plan[i].act, plan[i].val);
      end else begin
        typed_n = plan[i].nfix;
        typed[0] = plan[i].f0;
        typed[1] = plan[i].f1;
        send_item(plan[i].act, plan[i].val[7:0], plan[i].ok);
        typed_n = -1;
      end
    end

    while (live_items < TARGET_ITEMS) run_session();

    in_valid = 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d live and %0d dropped events over %0d sessions",
             live_items, dead_items, sessions);
    $display("checked %0d result beats: %0d blocks committed, %0d long blocks sent",
             beats_seen, commits, long_blocks);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/xcrc_pkg.sv
src/xcrc_front.sv
src/xcrc_queue.sv
src/xcrc_back.sv
src/xmodem_crc_block_receiver.sv
test/xmodem_crc_block_receiver_test.sv
